@@ sv/pctc_pkg.sv @@
// Shared types and constants for the prefix code table codec.
package pctc_pkg;

    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned LEN_W6 = 6;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2,
        OP_START  = 2'd3
    } opcode_t;

    // Result kinds.
    typedef enum logic {
        KIND_CODE   = 1'b0,
        KIND_SYMBOL = 1'b1
    } result_kind_t;

    // Control from the sequencer to the shared comparator.
    typedef struct packed {
        logic clear;
        logic compare;
    } cmp_ctl_t;

endpackage

@@ sv/pctc_table.sv @@
// Code table memory with per-entry valid bits and a registered read port.
module pctc_table #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8,
    parameter int unsigned LEN_W  = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [LEN_W-1:0]          wr_len,
    input  logic [pctc_pkg::CODE_W-1:0] wr_code,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [LEN_W-1:0]          rd_len,
    output logic [pctc_pkg::CODE_W-1:0] rd_code
);

    localparam int unsigned ENTRY_W = LEN_W + pctc_pkg::CODE_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    // The memory itself has no reset; a cleared valid bit reads as an empty entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_len, wr_code};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_len  = rd_vld_reg ? rd_data_reg[ENTRY_W-1:pctc_pkg::CODE_W] : '0;
    assign rd_code = rd_data_reg[pctc_pkg::CODE_W-1:0];

endmodule

@@ sv/pctc_match.sv @@
// Shared comparator that checks one table entry per cycle against the key.
module pctc_match #(
    parameter int unsigned ADDR_W = 8,
    parameter int unsigned LEN_W  = 6,
    parameter int unsigned KEY_W  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pctc_pkg::cmp_ctl_t          ctl,
    input  logic [ADDR_W-1:0]           cmp_addr,
    input  logic [LEN_W-1:0]            entry_len,
    input  logic [pctc_pkg::CODE_W-1:0] entry_code,
    input  logic [LEN_W-1:0]            key_len,
    input  logic [KEY_W-1:0]            key_bits,
    output logic                        hit,
    output logic [ADDR_W-1:0]           hit_addr
);

    localparam int unsigned CMP_W = (KEY_W > pctc_pkg::CODE_W) ? KEY_W : pctc_pkg::CODE_W;

    logic               match;
    logic               hit_reg;
    logic [ADDR_W-1:0]  hit_addr_reg;

    assign match = (entry_len == key_len) && (CMP_W'(entry_code) == CMP_W'(key_bits));

    // Entries are scanned in rising order, so the last match is the highest symbol.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.compare && match)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.compare && match)
        begin
            hit_addr_reg <= cmp_addr;
        end
    end

    assign hit      = hit_reg;
    assign hit_addr = hit_addr_reg;

endmodule

@@ sv/prefix_code_table_codec.sv @@
// Top level of the prefix code table codec: sequencer, key and result registers.
//
// Channel   Signals                                            Handshake
// -------   -------------------------------------------------  -----------------------------
// request   opcode, symbol, code_word, code_length, coded_bit  taken when start & !busy
// result    result_kind, out_symbol, out_code, out_length      one cycle, marked result_valid
//
// A load or start request is done as it is taken and busy stays low. An encode request for
// a symbol in range holds busy in ST_ENC while the table is read. A decode request holds busy
// while the single comparator visits one table entry per cycle, and ST_LAST and ST_OUT then
// drain the registered read and report. A decode bit that finds the key already full is
// dropped and busy stays low. Reset clears the key, the valid bit of every table entry and
// the sequencer; no clearing pass is needed. Results cannot be stalled: each one is shown
// for exactly one cycle, and the receiver must take it then.
module prefix_code_table_codec #(
    parameter int unsigned MAX_CODE_LEN = 32,
    parameter int unsigned SYMBOL_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [pctc_pkg::SYM_W-1:0]    symbol,
    input  logic [pctc_pkg::CODE_W-1:0]   code_word,
    input  logic [pctc_pkg::LEN_W6-1:0]   code_length,
    input  logic                          coded_bit,
    output logic                          result_valid,
    output logic                          result_kind,
    output logic [pctc_pkg::SYM_W-1:0]    out_symbol,
    output logic [pctc_pkg::CODE_W-1:0]   out_code,
    output logic [pctc_pkg::LEN_W6-1:0]   out_length
);

    localparam int unsigned ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int unsigned LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned KEY_W  = MAX_CODE_LEN;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ENC  = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_LAST = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]  key_bits_reg, key_bits_next;
    logic [LEN_W-1:0]  key_len_reg,  key_len_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic [ADDR_W-1:0] cmp_addr_reg;
    logic [pctc_pkg::SYM_W-1:0] sym_reg;

    logic                        res_vld_reg,  res_vld_next;
    logic                        res_kind_reg, res_kind_next;
    logic [pctc_pkg::SYM_W-1:0]  res_sym_reg,  res_sym_next;
    logic [pctc_pkg::CODE_W-1:0] res_code_reg, res_code_next;
    logic [pctc_pkg::LEN_W6-1:0] res_len_reg,  res_len_next;

    logic                        accept;
    logic                        sym_in_range;
    logic [LEN_W-1:0]            load_len;
    logic [pctc_pkg::CODE_W-1:0] load_mask;

    logic                        tbl_wr_en;
    logic                        tbl_rd_en;
    logic [ADDR_W-1:0]           tbl_rd_addr;
    logic [LEN_W-1:0]            tbl_rd_len;
    logic [pctc_pkg::CODE_W-1:0] tbl_rd_code;

    pctc_pkg::cmp_ctl_t          cmp_ctl;
    logic                        hit;
    logic [ADDR_W-1:0]           hit_addr;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Symbols past the end of the table are ignored by load and encode.
    assign sym_in_range = ({1'b0, symbol} < (pctc_pkg::SYM_W + 1)'(SYMBOL_COUNT));

    // Load lengths saturate at the longest code, and code bits above the length are dropped.
    always_comb
    begin
        if ({1'b0, code_length} > 7'(MAX_CODE_LEN))
        begin
            load_len = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            load_len = LEN_W'(code_length);
        end
        if (7'(load_len) >= 7'(pctc_pkg::CODE_W))
        begin
            load_mask = '1;
        end
        else
        begin
            load_mask = (pctc_pkg::CODE_W'(1) << load_len) - pctc_pkg::CODE_W'(1);
        end
    end

    assign tbl_wr_en = accept && (pctc_pkg::opcode_t'(opcode) == pctc_pkg::OP_LOAD)
                       && sym_in_range;

    // The read port serves the encode lookup and the decode scan, never both at once.
    always_comb
    begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = scan_addr_reg;
        if (state_reg == ST_SCAN)
        begin
            tbl_rd_en = 1'b1;
        end
        else if (accept && (pctc_pkg::opcode_t'(opcode) == pctc_pkg::OP_ENCODE))
        begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = ADDR_W'(symbol);
        end
    end

    pctc_table #(
        .DEPTH  (SYMBOL_COUNT),
        .ADDR_W (ADDR_W),
        .LEN_W  (LEN_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (ADDR_W'(symbol)),
        .wr_len  (load_len),
        .wr_code (code_word & load_mask),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_len  (tbl_rd_len),
        .rd_code (tbl_rd_code)
    );

    // The comparator is cleared as a decode bit is taken and then sees each entry
    // in the cycle after its read is issued.
    assign cmp_ctl.clear   = accept && (pctc_pkg::opcode_t'(opcode) == pctc_pkg::OP_DECODE);
    assign cmp_ctl.compare = cmp_pend_reg;

    pctc_match #(
        .ADDR_W (ADDR_W),
        .LEN_W  (LEN_W),
        .KEY_W  (KEY_W)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cmp_ctl),
        .cmp_addr   (cmp_addr_reg),
        .entry_len  (tbl_rd_len),
        .entry_code (tbl_rd_code),
        .key_len    (key_len_reg),
        .key_bits   (key_bits_reg),
        .hit        (hit),
        .hit_addr   (hit_addr)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        key_bits_next  = key_bits_reg;
        key_len_next   = key_len_reg;
        scan_addr_next = scan_addr_reg;
        cmp_pend_next  = 1'b0;
        res_vld_next   = 1'b0;
        res_kind_next  = res_kind_reg;
        res_sym_next   = res_sym_reg;
        res_code_next  = res_code_reg;
        res_len_next   = res_len_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (pctc_pkg::opcode_t'(opcode))
                        pctc_pkg::OP_LOAD:
                        begin
                            // The table write happens on this edge; nothing else to do.
                        end
                        pctc_pkg::OP_ENCODE:
                        begin
                            if (sym_in_range)
                            begin
                                state_next = ST_ENC;
                            end
                        end
                        pctc_pkg::OP_DECODE:
                        begin
                            // A full key drops further bits until the next stream start.
                            if (key_len_reg != LEN_W'(MAX_CODE_LEN))
                            begin
                                key_bits_next  = KEY_W'({key_bits_reg, coded_bit});
                                key_len_next   = key_len_reg + LEN_W'(1);
                                scan_addr_next = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        pctc_pkg::OP_START:
                        begin
                            key_bits_next = '0;
                            key_len_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ENC:
            begin
                // An empty entry gives no result.
                if (tbl_rd_len != '0)
                begin
                    res_vld_next  = 1'b1;
                    res_kind_next = pctc_pkg::KIND_CODE;
                    res_sym_next  = sym_reg;
                    res_code_next = tbl_rd_code;
                    res_len_next  = pctc_pkg::LEN_W6'(tbl_rd_len);
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmp_pend_next = 1'b1;
                if (scan_addr_reg == ADDR_W'(SYMBOL_COUNT - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
            end
            ST_LAST:
            begin
                // The last entry is compared on this edge.
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (hit)
                begin
                    res_vld_next  = 1'b1;
                    res_kind_next = pctc_pkg::KIND_SYMBOL;
                    res_sym_next  = pctc_pkg::SYM_W'(hit_addr);
                    res_code_next = pctc_pkg::CODE_W'(key_bits_reg);
                    res_len_next  = pctc_pkg::LEN_W6'(key_len_reg);
                    key_bits_next = '0;
                    key_len_next  = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            key_bits_reg <= '0;
            key_len_reg  <= '0;
            cmp_pend_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            key_bits_reg <= key_bits_next;
            key_len_reg  <= key_len_next;
            cmp_pend_reg <= cmp_pend_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        cmp_addr_reg  <= scan_addr_reg;
        res_kind_reg  <= res_kind_next;
        res_sym_reg   <= res_sym_next;
        res_code_reg  <= res_code_next;
        res_len_reg   <= res_len_next;
        if (accept)
        begin
            sym_reg <= symbol;
        end
    end

    assign result_valid = res_vld_reg;
    assign result_kind  = res_kind_reg;
    assign out_symbol   = res_sym_reg;
    assign out_code     = res_code_reg;
    assign out_length   = res_len_reg;

endmodule
